// ===== design/hsc_pkg.sv =====
// Shared types, field widths and position helpers for the Hamming SEC codec.
package hsc_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int DataW = 32;
  localparam int CodeW = 38;
  localparam int SynW  = 6;
  localparam int CfgW  = 6;

  // Operation codes carried in the action field.
  localparam logic ActEncode = 1'b0;
  localparam logic ActDecode = 1'b1;

  // One input item.
  typedef struct packed {
    logic             action;
    logic [DataW-1:0] data_word;
    logic [CodeW-1:0] code_word;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [CodeW-1:0] code_out;
    logic [DataW-1:0] data_out;
    logic [SynW-1:0]  syndrome;
    logic             error_found;
    logic             position_invalid;
  } out_t;

  // Code length n = m + r, with r the least count satisfying 2^r >= m + r + 1.
  function automatic int code_length(input int m);
    int r;
    r = 0;
    while (r < 7 && (1 << r) < m + r + 1) begin
      r++;
    end
    return m + r;
  endfunction

  // One-based code position that carries data bit d (the d-th non-power-of-two).
  function automatic int data_pos(input int d);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p < 128; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == d && pos == 0) begin
          pos = p;
        end
        cnt++;
      end
    end
    return pos;
  endfunction

endpackage

// ===== design/hsc_syndrome.sv =====
// Syndrome XOR trees: each bit is the parity of all positions that have that index bit set.
module hsc_syndrome #(
  parameter int CodeBits = 38
) (
  input  logic [CodeBits-1:0]      word_i,
  output logic [hsc_pkg::SynW-1:0] syndrome_o
);

  // One XOR reduction per syndrome bit over a fixed set of positions.
  always_comb begin
    syndrome_o = '0;
    for (int j = 0; j < hsc_pkg::SynW; j++) begin
      for (int p = 1; p <= CodeBits; p++) begin
        if (((p >> j) & 1) != 0) begin
          syndrome_o[j] = syndrome_o[j] ^ word_i[p-1];
        end
      end
    end
  end

endmodule

// ===== design/hsc_encoder.sv =====
// Encoder: scatters data bits over the code positions and fills in the parity bits.
module hsc_encoder #(
  parameter int MaxData  = 32,
  parameter int CodeBits = 38
) (
  input  logic [hsc_pkg::DataW-1:0] data_word_i,
  input  logic [hsc_pkg::SynW-1:0]  m_i,
  output hsc_pkg::out_t             result_o
);

  localparam int DExtW = (MaxData > hsc_pkg::DataW) ? MaxData : hsc_pkg::DataW;
  localparam int CExtW = (CodeBits > hsc_pkg::CodeW) ? CodeBits : hsc_pkg::CodeW;

  logic [hsc_pkg::DataW-1:0] data_m;
  logic [DExtW-1:0]          data_ext;
  logic [CodeBits-1:0]       word_data;
  logic [CodeBits-1:0]       word_full;
  logic [CExtW-1:0]          word_ext;
  logic [hsc_pkg::SynW-1:0]  syn;

  // Keep only the data bits in use.
  always_comb begin
    for (int d = 0; d < hsc_pkg::DataW; d++) begin
      data_m[d] = data_word_i[d] & (hsc_pkg::SynW'(d) < m_i);
    end
  end

  assign data_ext = DExtW'(data_m);

  // Fixed wiring of data bits onto non-power-of-two positions.
  always_comb begin
    word_data = '0;
    for (int d = 0; d < MaxData; d++) begin
      word_data[hsc_pkg::data_pos(d) - 1] = data_ext[d];
    end
  end

  // With the parity positions still zero, the syndrome is the parity to insert.
  hsc_syndrome #(
    .CodeBits(CodeBits)
  ) u_syndrome (
    .word_i    (word_data),
    .syndrome_o(syn)
  );

  // Parity bit j goes to position 2^j.
  always_comb begin
    word_full = word_data;
    for (int i = 0; i < CodeBits; i++) begin
      if (((i + 1) & i) == 0) begin
        word_full[i] = syn[$clog2(i + 1)];
      end
    end
  end

  assign word_ext = CExtW'(word_full);

  // Encode results carry no error report.
  always_comb begin
    result_o                  = '0;
    result_o.code_out         = word_ext[hsc_pkg::CodeW-1:0];
    result_o.data_out         = data_m;
    result_o.syndrome         = '0;
    result_o.error_found      = 1'b0;
    result_o.position_invalid = 1'b0;
  end

endmodule

// ===== design/hsc_decoder.sv =====
// Decoder: computes the syndrome, corrects one bit and extracts the data bits.
module hsc_decoder #(
  parameter int MaxData  = 32,
  parameter int CodeBits = 38
) (
  input  logic [hsc_pkg::CodeW-1:0] code_word_i,
  input  logic [hsc_pkg::SynW-1:0]  n_i,
  output hsc_pkg::out_t             result_o
);

  localparam int CExtW = (CodeBits > hsc_pkg::CodeW) ? CodeBits : hsc_pkg::CodeW;
  localparam int DExtW = (MaxData > hsc_pkg::DataW) ? MaxData : hsc_pkg::DataW;

  logic [CExtW-1:0]         cw_ext;
  logic [CodeBits-1:0]      word_in;
  logic [CodeBits-1:0]      word_fix;
  logic [CExtW-1:0]         fix_ext;
  logic [DExtW-1:0]         data_ext;
  logic [hsc_pkg::SynW-1:0] syn;
  logic                     err;
  logic                     inval;

  assign cw_ext = CExtW'(code_word_i);

  // Drop positions beyond the code length.
  always_comb begin
    for (int i = 0; i < CodeBits; i++) begin
      word_in[i] = cw_ext[i] & (hsc_pkg::SynW'(i) < n_i);
    end
  end

  hsc_syndrome #(
    .CodeBits(CodeBits)
  ) u_syndrome (
    .word_i    (word_in),
    .syndrome_o(syn)
  );

  assign err   = (syn != '0);
  assign inval = err && (syn > n_i);

  // Flip the bit the syndrome points at, unless it lies outside the code.
  always_comb begin
    for (int i = 0; i < CodeBits; i++) begin
      word_fix[i] = word_in[i] ^ (err && !inval && (syn == hsc_pkg::SynW'(i + 1)));
    end
  end

  assign fix_ext = CExtW'(word_fix);

  // Gather the data bits back from their fixed positions.
  always_comb begin
    data_ext = '0;
    for (int d = 0; d < MaxData; d++) begin
      data_ext[d] = word_fix[hsc_pkg::data_pos(d) - 1];
    end
  end

  always_comb begin
    result_o                  = '0;
    result_o.code_out         = fix_ext[hsc_pkg::CodeW-1:0];
    result_o.data_out         = data_ext[hsc_pkg::DataW-1:0];
    result_o.syndrome         = syn;
    result_o.error_found      = err;
    result_o.position_invalid = inval;
  end

endmodule

// ===== design/hamming_sec_codec.sv =====
// Top level of the Hamming SEC codec: input register, encode/decode logic, result register.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+------------------------------
//   in      | in_valid_i/in_ready_o  | in_data_i  (action, words)
//   out     | out_valid_o/out_ready_i| out_data_o (code, data, flags)
//   cfg     | cfg_valid_i/cfg_ready_o| cfg_data_i (data_length)
//
// Each item passes from the input register through the XOR trees into the result register.
// While results are taken, a new item is taken every cycle; throughput is one item per clock.
// Reset sets data_length to 32 (limited to MAX_DATA_BITS) and empties both stages.
// When the result is not taken, the stages fill and in_ready_o drops after two items.
// Configuration transfers are always taken.
module hamming_sec_codec #(
  parameter int MAX_DATA_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  hsc_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output hsc_pkg::out_t            out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [hsc_pkg::CfgW-1:0] cfg_data_i
);

  localparam int MaxCode = hsc_pkg::code_length(MAX_DATA_BITS);
  localparam int ResetM  = (MAX_DATA_BITS < 32) ? MAX_DATA_BITS : 32;
  localparam int ResetN  = hsc_pkg::code_length(ResetM);

  logic [hsc_pkg::SynW-1:0] m_q, m_d;
  logic [hsc_pkg::SynW-1:0] n_q, n_d;
  logic                     s1_valid_q;
  hsc_pkg::in_t             s1_data_q;
  logic                     out_valid_q;
  hsc_pkg::out_t            out_data_q;
  hsc_pkg::out_t            out_data_d;
  hsc_pkg::out_t            enc_res;
  hsc_pkg::out_t            dec_res;
  logic                     out_free;

  // Configuration: clamp the data length and work out the code length once.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_data_i == '0) begin
      m_d = hsc_pkg::SynW'(1);
    end else if (cfg_data_i > hsc_pkg::SynW'(MAX_DATA_BITS)) begin
      m_d = hsc_pkg::SynW'(MAX_DATA_BITS);
    end else begin
      m_d = cfg_data_i;
    end
    n_d = hsc_pkg::SynW'(hsc_pkg::code_length(int'(m_d)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= hsc_pkg::SynW'(ResetM);
      n_q <= hsc_pkg::SynW'(ResetN);
    end else if (cfg_valid_i && cfg_ready_o) begin
      m_q <= m_d;
      n_q <= n_d;
    end
  end

  // Stage handshake: a stage takes a new item when empty or when it moves on.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // Both paths run in parallel; the action selects the result.
  hsc_encoder #(
    .MaxData (MAX_DATA_BITS),
    .CodeBits(MaxCode)
  ) u_encoder (
    .data_word_i(s1_data_q.data_word),
    .m_i        (m_q),
    .result_o   (enc_res)
  );

  hsc_decoder #(
    .MaxData (MAX_DATA_BITS),
    .CodeBits(MaxCode)
  ) u_decoder (
    .code_word_i(s1_data_q.code_word),
    .n_i        (n_q),
    .result_o   (dec_res)
  );

  assign out_data_d = (s1_data_q.action == hsc_pkg::ActDecode) ? dec_res : enc_res;

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted input item always lands in the input register.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted item did not reach the input register");

  // An item leaving the input register always lands in the result register.
  a_out_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_free |=> out_valid_q)
    else $error("item lost between the stages");

  // The error flag follows the syndrome.
  a_err_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.error_found == (out_data_o.syndrome != '0))
    else $error("error flag disagrees with the syndrome");

  // An out-of-range position is only reported for a real error beyond the code.
  a_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.position_invalid |->
      out_data_o.error_found && (out_data_o.syndrome > n_q))
    else $error("invalid position flagged for a syndrome inside the code");

  // The code length always covers the clamped data length.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q > m_q && m_q != '0)
    else $error("code length register out of step with data length");

endmodule
